// ===== rtl/jsu_pkg.sv =====
// jsu_pkg: shared types, codes and helper functions for the json string unescape decoder
`default_nettype none
package jsu_pkg;

  // result status codes
  localparam logic [1:0] ST_DATA   = 2'd0;
  localparam logic [1:0] ST_CLOSED = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;

  // error codes
  localparam logic [2:0] E_EOF    = 3'd0;
  localparam logic [2:0] E_CTRL   = 3'd1;
  localparam logic [2:0] E_ESC    = 3'd2;
  localparam logic [2:0] E_LONE   = 3'd3;
  localparam logic [2:0] E_PAIR   = 3'd4;
  localparam logic [2:0] E_NOTSTR = 3'd5;

  // request type codes
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_EOF  = 1'b1;

  // characters of interest
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // surrogate prefixes (top six bits of the 16-bit escape value)
  localparam logic [5:0] SUR_HIGH = 6'b110110;
  localparam logic [5:0] SUR_LOW  = 6'b110111;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // most results one input beat can cause
  localparam int unsigned MAX_RES = 4;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } jsu_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_byte;
    logic [2:0] error_code;
    logic       last;
  } jsu_out_t;

  // group of results caused by one input beat, entry 0 goes out first
  typedef struct packed {
    logic [2:0]                   cnt;
    logic [1:0]                   status;
    logic [2:0]                   err;
    logic [MAX_RES-1:0][7:0]      bytes;
  } jsu_grp_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } jsu_hex_t;

  // decode one ascii hex digit
  function automatic jsu_hex_t hex_digit(input logic [7:0] b);
    jsu_hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    case (b) inside
      [8'h30:8'h39]: h.val = b[3:0];
      [8'h41:8'h46],
      [8'h61:8'h66]: h.val = b[3:0] + 4'd9;
      default:       h.ok = 1'b0;
    endcase
    return h;
  endfunction

  // encode a code point as 1 to 4 utf-8 bytes
  function automatic jsu_grp_t utf8_enc(input logic [20:0] cp);
    jsu_grp_t g;
    g = '0;
    g.status = ST_DATA;
    if (cp < 21'h80) begin
      g.cnt      = 3'd1;
      g.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      g.cnt      = 3'd2;
      g.bytes[0] = {3'b110, cp[10:6]};
      g.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      g.cnt      = 3'd3;
      g.bytes[0] = {4'b1110, cp[15:12]};
      g.bytes[1] = {2'b10, cp[11:6]};
      g.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      g.cnt      = 3'd4;
      g.bytes[0] = {5'b11110, cp[20:18]};
      g.bytes[1] = {2'b10, cp[17:12]};
      g.bytes[2] = {2'b10, cp[11:6]};
      g.bytes[3] = {2'b10, cp[5:0]};
    end
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/jsu_decode.sv =====
// jsu_decode: parser state registers and per-beat result group generation
`default_nettype none
module jsu_decode (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  input  wire jsu_pkg::jsu_in_t in_data,
  output jsu_pkg::jsu_grp_t     grp
);

  typedef enum logic [6:0] {
    M_IDLE    = 7'b0000001,
    M_STR     = 7'b0000010,
    M_ESC     = 7'b0000100,
    M_HEX1    = 7'b0001000,
    M_WANT_BS = 7'b0010000,
    M_WANT_U  = 7'b0100000,
    M_HEX2    = 7'b1000000
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [9:0]  hi_r, hi_nxt;

  jsu_pkg::jsu_hex_t hex;
  logic [15:0]       acc_new;
  logic [20:0]       cp_pair;
  logic [7:0]        b;

  assign b       = in_data.in_byte;
  assign hex     = jsu_pkg::hex_digit(b);
  assign acc_new = {acc_r[11:0], hex.val};
  assign cp_pair = {1'b0, hi_r, acc_new[9:0]} + jsu_pkg::SUPP_BASE;

  // next state and result group for the incoming beat
  always_comb begin
    mode_nxt = mode_r;
    hcnt_nxt = hcnt_r;
    acc_nxt  = acc_r;
    hi_nxt   = hi_r;
    grp      = '0;
    if (in_fire) begin
      if (in_data.req_type == jsu_pkg::REQ_EOF) begin
        mode_nxt = M_IDLE;
        hcnt_nxt = 2'd0;
        acc_nxt  = '0;
        grp.cnt  = 3'd1;
        grp.status = jsu_pkg::ST_ERROR;
        grp.err  = jsu_pkg::E_EOF;
      end else begin
        case (mode_r)
          M_STR: begin
            if (b == jsu_pkg::CH_QUOTE) begin
              mode_nxt   = M_IDLE;
              grp.cnt    = 3'd1;
              grp.status = jsu_pkg::ST_CLOSED;
            end else if (b == jsu_pkg::CH_BSL) begin
              mode_nxt = M_ESC;
            end else if (b < jsu_pkg::CH_SPACE) begin
              mode_nxt   = M_IDLE;
              hcnt_nxt   = 2'd0;
              acc_nxt    = '0;
              grp.cnt    = 3'd1;
              grp.status = jsu_pkg::ST_ERROR;
              grp.err    = jsu_pkg::E_CTRL;
            end else begin
              grp.cnt      = 3'd1;
              grp.bytes[0] = b;
            end
          end
          M_ESC: begin
            mode_nxt = M_STR;
            grp.cnt  = 3'd1;
            case (b)
              jsu_pkg::CH_QUOTE,
              jsu_pkg::CH_BSL,
              jsu_pkg::CH_SLASH: grp.bytes[0] = b;
              jsu_pkg::CH_B:     grp.bytes[0] = 8'h08;
              jsu_pkg::CH_F:     grp.bytes[0] = 8'h0c;
              jsu_pkg::CH_N:     grp.bytes[0] = 8'h0a;
              jsu_pkg::CH_R:     grp.bytes[0] = 8'h0d;
              jsu_pkg::CH_T:     grp.bytes[0] = 8'h09;
              jsu_pkg::CH_U: begin
                mode_nxt = M_HEX1;
                hcnt_nxt = 2'd0;
                acc_nxt  = '0;
                grp.cnt  = 3'd0;
              end
              default: begin
                mode_nxt   = M_IDLE;
                hcnt_nxt   = 2'd0;
                acc_nxt    = '0;
                grp.status = jsu_pkg::ST_ERROR;
                grp.err    = jsu_pkg::E_ESC;
              end
            endcase
          end
          M_HEX1, M_HEX2: begin
            if (!hex.ok) begin
              mode_nxt   = M_IDLE;
              hcnt_nxt   = 2'd0;
              acc_nxt    = '0;
              grp.cnt    = 3'd1;
              grp.status = jsu_pkg::ST_ERROR;
              grp.err    = jsu_pkg::E_ESC;
            end else if (hcnt_r != 2'd3) begin
              acc_nxt  = acc_new;
              hcnt_nxt = hcnt_r + 2'd1;
            end else begin
              // fourth digit: the escape value is complete
              hcnt_nxt = 2'd0;
              acc_nxt  = '0;
              if (mode_r == M_HEX1) begin
                if (acc_new[15:10] == jsu_pkg::SUR_LOW) begin
                  mode_nxt   = M_IDLE;
                  grp.cnt    = 3'd1;
                  grp.status = jsu_pkg::ST_ERROR;
                  grp.err    = jsu_pkg::E_LONE;
                end else if (acc_new[15:10] == jsu_pkg::SUR_HIGH) begin
                  hi_nxt   = acc_new[9:0];
                  mode_nxt = M_WANT_BS;
                end else begin
                  mode_nxt = M_STR;
                  grp      = jsu_pkg::utf8_enc({5'd0, acc_new});
                end
              end else begin
                if (acc_new[15:10] != jsu_pkg::SUR_LOW) begin
                  mode_nxt   = M_IDLE;
                  grp.cnt    = 3'd1;
                  grp.status = jsu_pkg::ST_ERROR;
                  grp.err    = jsu_pkg::E_LONE;
                end else begin
                  mode_nxt = M_STR;
                  grp      = jsu_pkg::utf8_enc(cp_pair);
                end
              end
            end
          end
          M_WANT_BS: begin
            if (b == jsu_pkg::CH_BSL) begin
              mode_nxt = M_WANT_U;
            end else begin
              mode_nxt   = M_IDLE;
              hcnt_nxt   = 2'd0;
              acc_nxt    = '0;
              grp.cnt    = 3'd1;
              grp.status = jsu_pkg::ST_ERROR;
              grp.err    = jsu_pkg::E_PAIR;
            end
          end
          M_WANT_U: begin
            if (b == jsu_pkg::CH_U) begin
              mode_nxt = M_HEX2;
              hcnt_nxt = 2'd0;
              acc_nxt  = '0;
            end else begin
              mode_nxt   = M_IDLE;
              hcnt_nxt   = 2'd0;
              acc_nxt    = '0;
              grp.cnt    = 3'd1;
              grp.status = jsu_pkg::ST_ERROR;
              grp.err    = jsu_pkg::E_PAIR;
            end
          end
          // idle: waiting for an opening quote
          default: begin
            if (b == jsu_pkg::CH_QUOTE) begin
              mode_nxt = M_STR;
            end else begin
              mode_nxt   = M_IDLE;
              hcnt_nxt   = 2'd0;
              acc_nxt    = '0;
              grp.cnt    = 3'd1;
              grp.status = jsu_pkg::ST_ERROR;
              grp.err    = jsu_pkg::E_NOTSTR;
            end
          end
        endcase
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      hcnt_r <= 2'd0;
      acc_r  <= '0;
      hi_r   <= '0;
    end else begin
      mode_r <= mode_nxt;
      hcnt_r <= hcnt_nxt;
      acc_r  <= acc_nxt;
      hi_r   <= hi_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jsu_emit.sv =====
// jsu_emit: result group register that sends its entries one beat at a time
`default_nettype none
module jsu_emit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire jsu_pkg::jsu_grp_t grp,
  output logic                   can_load,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output jsu_pkg::jsu_out_t      out_data
);

  logic              vld_r, vld_nxt;
  logic [1:0]        idx_r, idx_nxt;
  jsu_pkg::jsu_grp_t grp_r, grp_nxt;
  logic              fire, is_last, load;

  assign is_last  = ({1'b0, idx_r} + 3'd1) == grp_r.cnt;
  assign fire     = vld_r && !out_stall;
  assign can_load = !vld_r || (fire && is_last);
  assign load     = can_load && (grp.cnt != 3'd0);

  // current entry on the output port
  assign out_valid           = vld_r;
  assign out_data.status     = grp_r.status;
  assign out_data.out_byte   = grp_r.bytes[idx_r];
  assign out_data.error_code = grp_r.err;
  assign out_data.last       = is_last;

  // step through the group, take the next one when the last beat leaves
  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    grp_nxt = grp_r;
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = 2'd0;
      grp_nxt = grp;
    end else if (fire) begin
      if (is_last) begin
        vld_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/json_string_unescape_decoder.sv =====
// json_string_unescape_decoder: top level of the json string unescape decoder
//
//   channel | direction | handshake          | beat
//   in_     | input     | in_valid/in_stall   | req_type, in_byte
//   out_    | output    | out_valid/out_stall | status, out_byte, error_code, last
//
// An input beat is decoded in the cycle it is accepted; its results sit in the
// group register and leave one per cycle, unless stalled, from the next cycle.
// A beat with zero or one result allows a new input beat every cycle unless
// stalled; a multi-byte utf-8 \u escape holds the input until all bytes leave.
// out_stall stalls the group register and, through it, the input.
// Reset (synchronous, rst_n low) returns to idle with no pending results.
`default_nettype none
module json_string_unescape_decoder (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire jsu_pkg::jsu_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output jsu_pkg::jsu_out_t     out_data
);

  logic              in_fire, can_load;
  jsu_pkg::jsu_grp_t grp;

  assign in_stall = !can_load;
  assign in_fire  = in_valid && !in_stall;

  // parser
  jsu_decode u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .grp     (grp)
  );

  // result sequencing
  jsu_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp       (grp),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // an input beat is taken only when the pending group is gone or finishing
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (!out_valid || (!out_stall && out_data.last)))
    else $error("input beat taken over a pending result group");

  // closed and error results stand alone
  a_single_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != jsu_pkg::ST_DATA) |-> out_data.last)
    else $error("status result not marked last");

  // non-data results carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != jsu_pkg::ST_DATA) |-> (out_data.out_byte == 8'd0))
    else $error("status result carries a data byte");

endmodule
`default_nettype wire
